[rtl/triangle_tangent_frame_unit_macros.svh]
// ----------------------------------------------------------------------------
// Triangle tangent frame unit: assertion macros
// Shared concurrent assertion forms for the RTL modules.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_FRAME_UNIT_MACROS_SVH
`define TRIANGLE_TANGENT_FRAME_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TTF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tangent frame assertion failed");

// Next-cycle implication, disabled during reset.
`define TTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tangent frame assertion failed");

`endif

[rtl/ttf_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle tangent frame package
// Shared constants, types and the quotient saturation function.
// ----------------------------------------------------------------------------
package ttf_pkg;

  localparam int POS_WIDTH_DEF = 32;
  localparam int UV_WIDTH_DEF  = 24;
  localparam int TRI_W         = 24;
  localparam int OUT_W         = 32;
  localparam int QUOT_W        = 33;
  localparam int FRAC_SHIFT    = 16;
  localparam int BCNT_W        = 6;
  localparam int QUEUE_DEPTH   = 2;
  localparam int COMP_W        = 3;

  // Corner phase codes.
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  // Job codes of the back end: the determinant first, then six components.
  localparam logic [COMP_W-1:0] JOB_DET   = 3'd0;
  localparam logic [COMP_W-1:0] JOB_TAN_X = 3'd1;
  localparam logic [COMP_W-1:0] JOB_TAN_Z = 3'd3;
  localparam logic [COMP_W-1:0] JOB_BIT_X = 3'd4;
  localparam logic [COMP_W-1:0] JOB_LAST  = 3'd6;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL0  = 7'b0000010,
    ST_MUL1  = 7'b0000100,
    ST_MUL2  = 7'b0001000,
    ST_EVAL  = 7'b0010000,
    ST_DITER = 7'b0100000,
    ST_FIN   = 7'b1000000
  } back_state_t;

  // Applies the sign and saturates the quotient magnitude to signed Q16.16.
  function automatic logic [OUT_W-1:0] sat_quot(input logic [QUOT_W-1:0] q,
                                                input logic ovf, input logic neg);
    logic [OUT_W-1:0] res;
    if (neg) begin
      if (ovf || (q > {2'b01, {(QUOT_W-2){1'b0}}})) begin
        res = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        res = -q[OUT_W-1:0];
      end
    end else begin
      if (ovf || (q[QUOT_W-1:QUOT_W-2] != 2'b00)) begin
        res = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
        res = q[OUT_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

[rtl/ttf_front.sv]
// ----------------------------------------------------------------------------
// Triangle tangent frame front end
// Buffers the first two corners and forms edges and UV deltas on the third.
// ----------------------------------------------------------------------------
module ttf_front import ttf_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  parameter int UV_WIDTH  = UV_WIDTH_DEF,
  parameter int EW        = POS_WIDTH + 1,
  parameter int DUW       = UV_WIDTH + 1,
  parameter int JW        = 6 * EW + 4 * DUW + TRI_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [POS_WIDTH-1:0] px,
  input  logic signed [POS_WIDTH-1:0] py,
  input  logic signed [POS_WIDTH-1:0] pz,
  input  logic signed [UV_WIDTH-1:0]  tu,
  input  logic signed [UV_WIDTH-1:0]  tv,
  input  q_stat_t                     q_stat,
  output logic                        push,
  output logic [JW-1:0]               job
);

  logic [1:0]                  phase;
  logic [TRI_W-1:0]            tri_cnt;
  logic signed [POS_WIDTH-1:0] a_pos [3];
  logic signed [POS_WIDTH-1:0] b_pos [3];
  logic signed [UV_WIDTH-1:0]  a_tex [2];
  logic signed [UV_WIDTH-1:0]  b_tex [2];
  logic signed [POS_WIDTH-1:0] p_in  [3];
  logic                        acc_in;

  assign p_in[0] = px;
  assign p_in[1] = py;
  assign p_in[2] = pz;

  // The third corner needs room in the queue; the first two never wait.
  assign in_ready = (phase != PH_C) || !q_stat.full;
  assign acc_in   = in_valid && in_ready;
  assign push     = acc_in && (phase == PH_C);

  // Edge and delta request for the back end.
  always_comb begin
    job = '0;
    for (int i = 0; i < 3; i++) begin
      job[i*EW +: EW]     = EW'(b_pos[i]) - EW'(a_pos[i]);
      job[(3+i)*EW +: EW] = EW'(p_in[i]) - EW'(a_pos[i]);
    end
    job[6*EW +: DUW]         = DUW'(b_tex[0]) - DUW'(a_tex[0]);
    job[6*EW + DUW +: DUW]   = DUW'(b_tex[1]) - DUW'(a_tex[1]);
    job[6*EW + 2*DUW +: DUW] = DUW'(tu) - DUW'(a_tex[0]);
    job[6*EW + 3*DUW +: DUW] = DUW'(tv) - DUW'(a_tex[1]);
    job[6*EW + 4*DUW +: TRI_W] = tri_cnt;
  end

  // Phase and triangle count.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_A;
      tri_cnt <= '0;
    end else if (acc_in) begin
      case (phase)
        PH_A: phase <= PH_B;
        PH_B: phase <= PH_C;
        default: begin
          phase   <= PH_A;
          tri_cnt <= tri_cnt + 1'b1;
        end
      endcase
    end
  end

  // Corner storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        a_pos[i] <= '0;
        b_pos[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        a_tex[i] <= '0;
        b_tex[i] <= '0;
      end
    end else if (acc_in && (phase == PH_A)) begin
      a_pos[0] <= px; a_pos[1] <= py; a_pos[2] <= pz;
      a_tex[0] <= tu; a_tex[1] <= tv;
    end else if (acc_in && (phase == PH_B)) begin
      b_pos[0] <= px; b_pos[1] <= py; b_pos[2] <= pz;
      b_tex[0] <= tu; b_tex[1] <= tv;
    end
  end

endmodule

[rtl/ttf_queue.sv]
// ----------------------------------------------------------------------------
// Triangle tangent frame request queue
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module ttf_queue import ttf_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] head,
  output q_stat_t      q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign head         = mem[rptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CW'(DEPTH));

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

[rtl/ttf_back.sv]
// ----------------------------------------------------------------------------
// Triangle tangent frame back end
// Shared multiplier and bit-serial divider that turn one request into a result.
// ----------------------------------------------------------------------------
`include "triangle_tangent_frame_unit_macros.svh"

module ttf_back import ttf_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  parameter int UV_WIDTH  = UV_WIDTH_DEF,
  parameter int EW        = POS_WIDTH + 1,
  parameter int DUW       = UV_WIDTH + 1,
  parameter int JW        = 6 * EW + 4 * DUW + TRI_W,
  parameter int OW        = 6 * OUT_W + TRI_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [JW-1:0] job,
  input  q_stat_t       q_stat,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [OW-1:0] out_data,
  output logic          out_degen
);

  localparam int BW = ((POS_WIDTH > UV_WIDTH) ? POS_WIDTH : UV_WIDTH) + 1;
  localparam int PW = DUW + BW;
  localparam int AW = PW + 1;
  localparam int SW = AW + FRAC_SHIFT;

  back_state_t           state;
  logic [COMP_W-1:0]     jcnt;
  logic signed [PW-1:0]  mprod;
  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  det;
  logic                  degen;
  logic [AW-1:0]         rem;
  logic [QUOT_W-1:0]     nsh;
  logic [QUOT_W-1:0]     quot;
  logic                  ovf;
  logic                  neg;
  logic [BCNT_W-1:0]     bcnt;
  logic [OUT_W-1:0]      res [6];

  logic signed [EW-1:0]  e1 [3];
  logic signed [EW-1:0]  e2 [3];
  logic signed [DUW-1:0] d1u, d1v, d2u, d2v;
  logic signed [DUW-1:0] op_a;
  logic signed [BW-1:0]  op_b;
  logic [1:0]            vi;
  logic                  term2;
  logic [AW-1:0]         dmag;
  logic [AW-1:0]         nmag;
  logic [SW-1:0]         nfull;
  logic [AW:0]           rtry;
  logic [AW:0]           rdif;
  logic [QUOT_W-1:0]     quot_next;
  logic                  out_free;

  // Request fields.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = job[i*EW +: EW];
      e2[i] = job[(3+i)*EW +: EW];
    end
  end
  assign d1u = job[6*EW +: DUW];
  assign d1v = job[6*EW + DUW +: DUW];
  assign d2u = job[6*EW + 2*DUW +: DUW];
  assign d2v = job[6*EW + 3*DUW +: DUW];

  // Operand selection for the shared multiplier.
  assign term2 = (state == ST_MUL1);
  assign vi    = (jcnt <= JOB_TAN_Z) ? 2'(jcnt - JOB_TAN_X) : 2'(jcnt - JOB_BIT_X);
  always_comb begin
    if (jcnt == JOB_DET) begin
      op_a = term2 ? d2u : d1u;
      op_b = term2 ? BW'(d1v) : BW'(d2v);
    end else if (jcnt <= JOB_TAN_Z) begin
      op_a = term2 ? d1v : d2v;
      op_b = term2 ? BW'(e2[vi]) : BW'(e1[vi]);
    end else begin
      op_a = term2 ? d2u : d1u;
      op_b = term2 ? BW'(e1[vi]) : BW'(e2[vi]);
    end
  end

  // Magnitudes and one restoring division step.
  assign dmag      = det[AW-1] ? AW'(-det) : AW'(det);
  assign nmag      = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign nfull     = {nmag, {FRAC_SHIFT{1'b0}}};
  assign rtry      = {rem, nsh[QUOT_W-1]};
  assign rdif      = rtry - {1'b0, dmag};
  assign quot_next = {quot[QUOT_W-2:0], !rdif[AW]};
  assign out_free  = !out_valid || out_ready;
  assign pop       = (state == ST_FIN) && out_free;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      jcnt  <= JOB_DET;
      bcnt  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            state <= ST_MUL0;
            jcnt  <= JOB_DET;
          end
        end
        ST_MUL0: state <= ST_MUL1;
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_EVAL;
        ST_EVAL: begin
          if (jcnt == JOB_DET) begin
            if (acc == '0) begin
              state <= ST_FIN;
            end else begin
              state <= ST_MUL0;
              jcnt  <= JOB_TAN_X;
            end
          end else begin
            state <= ST_DITER;
            bcnt  <= '0;
          end
        end
        ST_DITER: begin
          bcnt <= bcnt + 1'b1;
          if (bcnt == BCNT_W'(QUOT_W - 1)) begin
            if (jcnt == JOB_LAST) begin
              state <= ST_FIN;
            end else begin
              state <= ST_MUL0;
              jcnt  <= jcnt + 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath: products, accumulation, division.
  always_ff @(posedge clk) begin
    if (state == ST_MUL0 || state == ST_MUL1) begin
      mprod <= op_a * op_b;
    end
    if (state == ST_MUL1) begin
      acc <= AW'(mprod);
    end else if (state == ST_MUL2) begin
      acc <= acc - AW'(mprod);
    end
    if (state == ST_EVAL) begin
      if (jcnt == JOB_DET) begin
        det   <= acc;
        degen <= (acc == '0);
      end else begin
        rem  <= AW'(nfull[SW-1:QUOT_W]);
        ovf  <= (AW'(nfull[SW-1:QUOT_W]) >= dmag);
        nsh  <= nfull[QUOT_W-1:0];
        neg  <= acc[AW-1] ^ det[AW-1];
        quot <= '0;
      end
    end
    if (state == ST_DITER) begin
      quot <= quot_next;
      nsh  <= {nsh[QUOT_W-2:0], 1'b0};
      rem  <= rdif[AW] ? rtry[AW-1:0] : rdif[AW-1:0];
      if (bcnt == BCNT_W'(QUOT_W - 1)) begin
        res[COMP_W'(jcnt - JOB_TAN_X)] <= sat_quot(quot_next, ovf, neg);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_degen <= degen;
      for (int i = 0; i < 6; i++) begin
        out_data[i*OUT_W +: OUT_W] <= degen ? '0 : res[i];
      end
      out_data[6*OUT_W +: TRI_W] <= job[6*EW + 4*DUW +: TRI_W];
    end
  end

  `TTF_ASSERT_IMPL(a_degen_zero, clk, rst, out_valid && out_degen, out_data[6*OUT_W-1:0] == '0)
  `TTF_ASSERT_IMPL(a_iter_range, clk, rst, state == ST_DITER, bcnt < BCNT_W'(QUOT_W))
  `TTF_ASSERT_NEXT(a_fin_loads, clk, rst, pop, out_valid && (state == ST_IDLE))
  `TTF_ASSERT_IMPL(a_pop_has_job, clk, rst, pop, !q_stat.empty)

endmodule

[rtl/triangle_tangent_frame_unit.sv]
// ----------------------------------------------------------------------------
// Triangle tangent frame unit
// Per-triangle UV tangent and bitangent in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         one vertex: position and texture coordinate
//  m_axis    out        one triangle: tangent, bitangent, count, degenerate flag
//
//  Every vertex is taken as soon as it is offered; the third vertex of a
//  triangle waits only while the two-entry request queue is full.
//  The back end forms the determinant in three multiply states and one
//  evaluate state, then each of six components in three multiply states,
//  one set-up state and 33 divider steps, with an idle and a finish state.
//  It works on one triangle at a time, so the single shared bit-serial
//  divider sets the triangle rate; a degenerate one ends after the determinant.
//  Reset is synchronous and clears corner storage, phase, count and queue.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_unit import ttf_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  parameter int UV_WIDTH  = UV_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            s_axis_tvalid,
  output logic                                            s_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, zero fill
  input  logic [((3*POS_WIDTH + 2*UV_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  // tangent_x/y/z, bitangent_x/y/z, triangle_number
  output logic [6*OUT_W + TRI_W - 1:0]                    m_axis_tdata,
  // degenerate
  output logic                                            m_axis_tuser
);

  localparam int EW = POS_WIDTH + 1;
  localparam int DUW = UV_WIDTH + 1;
  localparam int JW = 6 * EW + 4 * DUW + TRI_W;

  logic          push;
  logic          pop;
  logic [JW-1:0] job_in;
  logic [JW-1:0] job_head;
  q_stat_t       q_stat;

  // Vertex intake and corner buffering.
  ttf_front #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .px       (s_axis_tdata[POS_WIDTH-1:0]),
    .py       (s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH]),
    .pz       (s_axis_tdata[3*POS_WIDTH-1:2*POS_WIDTH]),
    .tu       (s_axis_tdata[3*POS_WIDTH+UV_WIDTH-1:3*POS_WIDTH]),
    .tv       (s_axis_tdata[3*POS_WIDTH+2*UV_WIDTH-1:3*POS_WIDTH+UV_WIDTH]),
    .q_stat   (q_stat),
    .push     (push),
    .job      (job_in)
  );

  // Request queue.
  ttf_queue #(.W(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (job_in),
    .pop    (pop),
    .head   (job_head),
    .q_stat (q_stat)
  );

  // Arithmetic back end.
  ttf_back #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_degen (m_axis_tuser)
  );

endmodule
